// ===== sv/rna_pkg.sv =====
// ----------------------------------------------------------------------------
// rna_pkg
// Shared types and constants for the radius neighbor average block.
// ----------------------------------------------------------------------------
`default_nettype none

package rna_pkg;

    localparam int COORD_BITS       = 16;
    localparam int INDEX_BITS       = 6;
    localparam int RADIUS_BITS      = 32;
    localparam int ACTIVE_BITS      = 7;
    localparam int COUNT_OUT_BITS   = 6;
    localparam int MAX_AGENTS_DEF   = 64;
    localparam int S_DATA_BITS      = 72;
    localparam int M_DATA_BITS      = 72;

    localparam logic [RADIUS_BITS-1:0] RADIUS_SQ_RESET = 32'd14745600;
    localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET    = 7'd50;

    typedef enum logic [0:0] {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } command_t;

    typedef enum logic [0:0] {
        CFG_RADIUS_SQUARED = 1'b0,
        CFG_ACTIVE_AGENTS  = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic                         present;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] vel_x;
        logic signed [COORD_BITS-1:0] vel_y;
    } agent_entry_t;

    typedef struct packed {
        logic                  start;
        logic [INDEX_BITS-1:0] agent_index;
    } query_req_t;

endpackage

`default_nettype wire

// ===== sv/rna_agent_mem.sv =====
// ----------------------------------------------------------------------------
// rna_agent_mem
// Agent table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rna_agent_mem
    import rna_pkg::*;
#(
    parameter int MAX_AGENTS = MAX_AGENTS_DEF,
    localparam int AW        = $clog2(MAX_AGENTS)
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire agent_entry_t  wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output agent_entry_t       rd_data_reg
);

    agent_entry_t mem [MAX_AGENTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/rna_scan.sv =====
// ----------------------------------------------------------------------------
// rna_scan
// Query engine: looks up the queried agent, then streams table entries
// through a distance-square / compare / accumulate pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module rna_scan
    import rna_pkg::*;
#(
    parameter int MAX_AGENTS = MAX_AGENTS_DEF,
    localparam int AW        = $clog2(MAX_AGENTS),
    localparam int CNTW      = $clog2(MAX_AGENTS + 1),
    localparam int SUMW      = COORD_BITS + CNTW
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire query_req_t             req,
    input  wire logic [CNTW-1:0]        limit,
    input  wire logic [RADIUS_BITS-1:0] radius_sq,
    output logic                        rd_en,
    output logic [AW-1:0]               rd_addr,
    input  wire agent_entry_t           rd_data,
    output logic                        scan_done,
    output logic [CNTW-1:0]             count_reg,
    output logic signed [SUMW-1:0]      sum_px_reg,
    output logic signed [SUMW-1:0]      sum_py_reg,
    output logic signed [SUMW-1:0]      sum_vx_reg,
    output logic signed [SUMW-1:0]      sum_vy_reg
);

    localparam int IW  = (CNTW > INDEX_BITS) ? CNTW : INDEX_BITS;
    localparam int DW  = COORD_BITS + 1;
    localparam int SQW = 2 * COORD_BITS;

    logic                         busy_reg, busy_next;
    logic                         look_reg, look_next;
    logic                         iss_reg, iss_next;
    logic [CNTW-1:0]              iter_reg, iter_next;
    logic [INDEX_BITS-1:0]        qidx_reg;
    logic                         qin_reg;
    logic signed [COORD_BITS-1:0] qx_reg, qy_reg;
    logic                         p1_valid_reg, p1_valid_next;
    logic [CNTW-1:0]              p1_idx_reg;
    logic                         p2_valid_reg, p2_valid_next;
    logic                         p2_skip_reg, p2_skip_next;
    logic [SQW-1:0]               sqx_reg, sqy_reg, sqx_next, sqy_next;
    agent_entry_t                 p2_entry_reg;

    logic signed [DW-1:0]         dx, dy;
    logic signed [2*DW-1:0]       dx_sq, dy_sq;
    logic [SQW:0]                 dist_sq;
    logic                         hit;

    assign rd_en   = req.start | iss_reg;
    assign rd_addr = req.start ? AW'(req.agent_index) : iter_reg[AW-1:0];

    always_comb begin
        busy_next = busy_reg;
        look_next = 1'b0;
        iss_next  = iss_reg;
        iter_next = iter_reg;
        p1_valid_next = 1'b0;
        scan_done = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
            look_next = 1'b1;
            iss_next  = (limit != '0);
            iter_next = '0;
        end else begin
            if (iss_reg) begin
                p1_valid_next = 1'b1;
                iter_next     = CNTW'(iter_reg + 1'b1);
                if (CNTW'(iter_reg + 1'b1) == limit) begin
                    iss_next = 1'b0;
                end
            end
            if (busy_reg && !look_reg && !iss_reg && !p1_valid_reg && !p2_valid_reg) begin
                scan_done = 1'b1;
                busy_next = 1'b0;
            end
        end
    end

    // stage 1: squared axis distances
    always_comb begin
        dx       = DW'(rd_data.pos_x) - DW'(qx_reg);
        dy       = DW'(rd_data.pos_y) - DW'(qy_reg);
        dx_sq    = dx * dx;
        dy_sq    = dy * dy;
        sqx_next = dx_sq[SQW-1:0];
        sqy_next = dy_sq[SQW-1:0];
        p2_valid_next = p1_valid_reg;
        p2_skip_next  = !rd_data.present || (IW'(p1_idx_reg) == IW'(qidx_reg));
    end

    // stage 2: compare against the radius
    assign dist_sq = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign hit     = p2_valid_reg && !p2_skip_reg
                     && (dist_sq < (SQW + 1)'(radius_sq));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            look_reg     <= 1'b0;
            iss_reg      <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            look_reg     <= look_next;
            iss_reg      <= iss_next;
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        iter_reg     <= iter_next;
        p1_idx_reg   <= iter_reg;
        sqx_reg      <= sqx_next;
        sqy_reg      <= sqy_next;
        p2_skip_reg  <= p2_skip_next;
        p2_entry_reg <= rd_data;
        if (req.start) begin
            qidx_reg   <= req.agent_index;
            qin_reg    <= (IW'(req.agent_index) < IW'(MAX_AGENTS));
            count_reg  <= '0;
            sum_px_reg <= '0;
            sum_py_reg <= '0;
            sum_vx_reg <= '0;
            sum_vy_reg <= '0;
        end else if (hit) begin
            count_reg  <= CNTW'(count_reg + 1'b1);
            sum_px_reg <= sum_px_reg + SUMW'(p2_entry_reg.pos_x);
            sum_py_reg <= sum_py_reg + SUMW'(p2_entry_reg.pos_y);
            sum_vx_reg <= sum_vx_reg + SUMW'(p2_entry_reg.vel_x);
            sum_vy_reg <= sum_vy_reg + SUMW'(p2_entry_reg.vel_y);
        end
        if (look_reg) begin
            qx_reg <= qin_reg ? rd_data.pos_x : '0;
            qy_reg <= qin_reg ? rd_data.pos_y : '0;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rna_div_lane.sv =====
// ----------------------------------------------------------------------------
// rna_div_lane
// Signed sum by unsigned count, restoring division one bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rna_div_lane
    import rna_pkg::*;
#(
    parameter int SUMW = COORD_BITS + 7,
    parameter int CNTW = 7,
    localparam int STW = $clog2(SUMW)
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic signed [SUMW-1:0] dividend,
    input  wire logic [CNTW-1:0]        divisor,
    output logic                        busy_reg,
    output logic [COORD_BITS-1:0]       quotient
);

    logic [STW-1:0]        step_reg;
    logic                  neg_reg;
    logic [SUMW-1:0]       quo_reg, quo_next;
    logic [CNTW-1:0]       rem_reg, rem_next;
    logic [CNTW-1:0]       dvs_reg;
    logic [CNTW:0]         shifted;
    logic                  ge;
    logic [COORD_BITS-1:0] qlow;

    always_comb begin
        shifted  = {rem_reg, quo_reg[SUMW-1]};
        ge       = shifted >= {1'b0, dvs_reg};
        rem_next = ge ? CNTW'(shifted - {1'b0, dvs_reg}) : shifted[CNTW-1:0];
        quo_next = {quo_reg[SUMW-2:0], ge};
    end

    assign qlow     = quo_reg[COORD_BITS-1:0];
    assign quotient = neg_reg ? (~qlow + 1'b1) : qlow;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && step_reg == STW'(SUMW - 1)) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg  <= dividend[SUMW-1];
            quo_reg  <= dividend[SUMW-1] ? SUMW'(-dividend) : SUMW'(dividend);
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            step_reg <= '0;
        end else if (busy_reg) begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            step_reg <= STW'(step_reg + 1'b1);
        end
    end

endmodule

`default_nettype wire

// ===== sv/radius_neighbor_average.sv =====
// ----------------------------------------------------------------------------
// radius_neighbor_average
// Fixed-radius neighbor search over an agent table with mean position and
// velocity of the neighbors found.
// ----------------------------------------------------------------------------
// Write word: written to the table, next word taken in the following cycle.
// Query word: scans min(active agents, MAX_AGENTS) table entries (one read per cycle),
//   then divides the sums in SUMW = 16 + clog2(MAX_AGENTS+1) divide steps; no further
//   word is taken until the result is loaded into the output register.
// Reset: synchronous, active low; the table is then cleared entry by entry
//   with s_tready low. Config writes are taken at any time.
`default_nettype none

module radius_neighbor_average
    import rna_pkg::*;
#(
    parameter int MAX_AGENTS = MAX_AGENTS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // cfg
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [0:0]             cfg_index,
    input  wire logic [RADIUS_BITS-1:0] cfg_data,
    // input words
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // agent_index[5:0], present[6], pos_x[22:7], pos_y[38:23],
    // vel_x[54:39], vel_y[70:55], zero pad[71]
    input  wire logic [S_DATA_BITS-1:0] s_tdata,
    // command[0]
    input  wire logic                   s_tuser,
    // result words
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // neighbor_count[5:0], avg_pos_x[21:6], avg_pos_y[37:22],
    // avg_vel_x[53:38], avg_vel_y[69:54], zero pad[71:70]
    output logic [M_DATA_BITS-1:0]      m_tdata,
    // no_neighbors[0]
    output logic                        m_tuser
);

    localparam int AW   = $clog2(MAX_AGENTS);
    localparam int CNTW = $clog2(MAX_AGENTS + 1);
    localparam int SUMW = COORD_BITS + CNTW;
    localparam int IW   = (CNTW > INDEX_BITS) ? CNTW : INDEX_BITS;
    localparam int WW   = (CNTW > ACTIVE_BITS) ? CNTW : ACTIVE_BITS;

    state_t                 state_reg, state_next;
    logic [RADIUS_BITS-1:0] radius_sq_reg;
    logic [ACTIVE_BITS-1:0] active_reg;
    logic [AW-1:0]          clr_addr_reg;
    logic                   m_tvalid_reg;
    logic [M_DATA_BITS-1:0] m_tdata_reg;
    logic                   m_tuser_reg;

    logic                   s_accept;
    logic [INDEX_BITS-1:0]  in_index;
    logic                   in_table;
    agent_entry_t           in_entry;
    logic                   clr_last;

    logic                   mem_wr_en;
    logic [AW-1:0]          mem_wr_addr;
    agent_entry_t           mem_wr_data;
    logic                   mem_rd_en;
    logic [AW-1:0]          mem_rd_addr;
    agent_entry_t           mem_rd_data;

    query_req_t             qreq;
    logic [CNTW-1:0]        limit;
    logic                   scan_done;
    logic [CNTW-1:0]        count;
    logic signed [SUMW-1:0] sum_px, sum_py, sum_vx, sum_vy;

    logic                   div_start;
    logic                   busy_px, busy_py, busy_vx, busy_vy, div_busy;
    logic [COORD_BITS-1:0]  avg_px, avg_py, avg_vx, avg_vy;

    logic                   out_load;
    logic                   no_nb;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign s_accept = s_tvalid && s_tready;
    assign in_index = s_tdata[5:0];
    assign in_table = IW'(in_index) < IW'(MAX_AGENTS);
    assign in_entry = '{present: s_tdata[6],
                        pos_x:   s_tdata[22:7],
                        pos_y:   s_tdata[38:23],
                        vel_x:   s_tdata[54:39],
                        vel_y:   s_tdata[70:55]};
    assign clr_last = clr_addr_reg == AW'(MAX_AGENTS - 1);

    always_comb begin
        limit = (WW'(active_reg) > WW'(MAX_AGENTS)) ? CNTW'(MAX_AGENTS)
                                                     : CNTW'(active_reg);
    end

    // cfg registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_sq_reg <= RADIUS_SQ_RESET;
            active_reg    <= ACTIVE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_RADIUS_SQUARED: radius_sq_reg <= cfg_data;
                CFG_ACTIVE_AGENTS:  active_reg    <= cfg_data[ACTIVE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_accept && s_tuser == CMD_QUERY) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_done) state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (!div_busy) state_next = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready    = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = AW'(in_index);
        mem_wr_data = in_entry;
        qreq        = '{start: 1'b0, agent_index: in_index};
        div_start   = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_addr_reg;
                mem_wr_data = '0;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_accept) begin
                    if (s_tuser == CMD_QUERY) begin
                        qreq.start = 1'b1;
                    end else begin
                        mem_wr_en = in_table;
                    end
                end
            end
            ST_SCAN: begin
                div_start = scan_done;
            end
            ST_DIVIDE: ;
            ST_OUTPUT: begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= AW'(clr_addr_reg + 1'b1);
            end
        end
    end

    // result register
    assign no_nb = (count == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tuser_reg <= no_nb;
            m_tdata_reg <= {2'b00,
                            no_nb ? '0 : avg_vy,
                            no_nb ? '0 : avg_vx,
                            no_nb ? '0 : avg_py,
                            no_nb ? '0 : avg_px,
                            COUNT_OUT_BITS'(count)};
        end
    end

    rna_agent_mem #(
        .MAX_AGENTS (MAX_AGENTS)
    ) u_mem (
        .aclk        (aclk),
        .wr_en       (mem_wr_en),
        .wr_addr     (mem_wr_addr),
        .wr_data     (mem_wr_data),
        .rd_en       (mem_rd_en),
        .rd_addr     (mem_rd_addr),
        .rd_data_reg (mem_rd_data)
    );

    rna_scan #(
        .MAX_AGENTS (MAX_AGENTS)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (qreq),
        .limit      (limit),
        .radius_sq  (radius_sq_reg),
        .rd_en      (mem_rd_en),
        .rd_addr    (mem_rd_addr),
        .rd_data    (mem_rd_data),
        .scan_done  (scan_done),
        .count_reg  (count),
        .sum_px_reg (sum_px),
        .sum_py_reg (sum_py),
        .sum_vx_reg (sum_vx),
        .sum_vy_reg (sum_vy)
    );

    rna_div_lane #(.SUMW(SUMW), .CNTW(CNTW)) u_div_px (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(sum_px),
        .divisor(count), .busy_reg(busy_px), .quotient(avg_px)
    );

    rna_div_lane #(.SUMW(SUMW), .CNTW(CNTW)) u_div_py (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(sum_py),
        .divisor(count), .busy_reg(busy_py), .quotient(avg_py)
    );

    rna_div_lane #(.SUMW(SUMW), .CNTW(CNTW)) u_div_vx (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(sum_vx),
        .divisor(count), .busy_reg(busy_vx), .quotient(avg_vx)
    );

    rna_div_lane #(.SUMW(SUMW), .CNTW(CNTW)) u_div_vy (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(sum_vy),
        .divisor(count), .busy_reg(busy_vy), .quotient(avg_vy)
    );

    assign div_busy = busy_px | busy_py | busy_vx | busy_vy;

    // table writes never overlap a running scan
    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> (state_reg == ST_CLEAR || state_reg == ST_IDLE))
        else $error("table write outside idle or clear");

    a_done_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_done |-> state_reg == ST_SCAN)
        else $error("scan finished outside scan state");

    a_div_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> state_reg == ST_DIVIDE)
        else $error("divider running outside divide state");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tdata[69:6] == '0)
        else $error("empty neighborhood with nonzero averages");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for radius_neighbor_average. Agent table writes and
// neighbor queries go in mostly with random gaps, results are pulled mostly
// with random stalls and one long hold-off; every result word is compared
// against an in-bench neighbor search kept in step with the accepted words.
// Register settings are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import rna_pkg::*;

    localparam int TAB_DEPTH      = 64;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 120;
    localparam int PHASE_WORDS    = 230;
    localparam int NUM_PHASES     = 8;

    typedef struct {
        command_t                     cmd;
        logic [INDEX_BITS-1:0]        idx;
        logic                         present;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] vx;
        logic signed [COORD_BITS-1:0] vy;
    } agent_word_t;

    typedef struct {
        logic [COUNT_OUT_BITS-1:0]    count;
        logic                         empty;
        logic signed [COORD_BITS-1:0] apx;
        logic signed [COORD_BITS-1:0] apy;
        logic signed [COORD_BITS-1:0] avx;
        logic signed [COORD_BITS-1:0] avy;
    } nbr_result_t;

    class neighbor_scoreboard;
        logic [RADIUS_BITS-1:0]       radius_sq;
        logic [ACTIVE_BITS-1:0]       scan_len;
        bit                           live[TAB_DEPTH];
        logic signed [COORD_BITS-1:0] px_tab[TAB_DEPTH];
        logic signed [COORD_BITS-1:0] py_tab[TAB_DEPTH];
        logic signed [COORD_BITS-1:0] vx_tab[TAB_DEPTH];
        logic signed [COORD_BITS-1:0] vy_tab[TAB_DEPTH];
        nbr_result_t                  pending[$];
        int                           failures;
        int                           checked;
        int                           writes;
        int                           queries;
        int                           empties;

        function new();
            radius_sq = RADIUS_SQ_RESET;
            scan_len  = ACTIVE_RESET;
            foreach (live[i]) begin
                live[i]   = 1'b0;
                px_tab[i] = '0;
                py_tab[i] = '0;
                vx_tab[i] = '0;
                vy_tab[i] = '0;
            end
            failures = 0;
            checked  = 0;
            writes   = 0;
            queries  = 0;
            empties  = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [RADIUS_BITS-1:0] value);
            case (idx)
                CFG_RADIUS_SQUARED: radius_sq = value;
                CFG_ACTIVE_AGENTS:  scan_len = value[ACTIVE_BITS-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [COORD_BITS-1:0] mean16(longint total, int n);
            longint q;
            if (n == 0) return '0;
            q = total / n;
            return q[COORD_BITS-1:0];
        endfunction

        function void note_word(logic [S_DATA_BITS-1:0] data, logic cmd);
            logic [INDEX_BITS-1:0] idx;
            longint                qx, qy, dx, dy, spx, spy, svx, svy;
            int                    n, lim;
            nbr_result_t           r;
            idx = data[5:0];
            if (command_t'(cmd) == CMD_WRITE) begin
                live[idx]   = data[6];
                px_tab[idx] = data[22:7];
                py_tab[idx] = data[38:23];
                vx_tab[idx] = data[54:39];
                vy_tab[idx] = data[70:55];
                writes++;
                return;
            end
            queries++;
            qx  = px_tab[idx];
            qy  = py_tab[idx];
            lim = (scan_len > TAB_DEPTH) ? TAB_DEPTH : int'(scan_len);
            n   = 0;
            spx = 0;
            spy = 0;
            svx = 0;
            svy = 0;
            for (int i = 0; i < lim; i++) begin
                if (i == int'(idx) || !live[i]) continue;
                dx = px_tab[i] - qx;
                dy = py_tab[i] - qy;
                if (dx * dx + dy * dy < longint'(radius_sq)) begin
                    n++;
                    spx += px_tab[i];
                    spy += py_tab[i];
                    svx += vx_tab[i];
                    svy += vy_tab[i];
                end
            end
            r.count = n[COUNT_OUT_BITS-1:0];
            r.empty = (n == 0);
            r.apx   = mean16(spx, n);
            r.apy   = mean16(spy, n);
            r.avx   = mean16(svx, n);
            r.avy   = mean16(svy, n);
            pending.insert(pending.size(), r);
        endfunction

        function void cmp_field(string name, longint want, longint got);
            if (want != got) begin
                failures++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [M_DATA_BITS-1:0] data, logic flag);
            nbr_result_t e;
            if (pending.size() == 0) begin
                failures++;
                $display("%0t: result word with no query outstanding: expected none, actual %h/%b",
                         $time, data, flag);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e.empty) empties++;
            cmp_field("neighbor_count", e.count, data[5:0]);
            cmp_field("no_neighbors", e.empty, flag);
            cmp_field("avg_pos_x", e.apx, $signed(data[21:6]));
            cmp_field("avg_pos_y", e.apy, $signed(data[37:22]));
            cmp_field("avg_vel_x", e.avx, $signed(data[53:38]));
            cmp_field("avg_vel_y", e.avy, $signed(data[69:54]));
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [0:0]             cfg_index;
    logic [RADIUS_BITS-1:0] cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_BITS-1:0] m_tdata;
    logic                   m_tuser;

    neighbor_scoreboard sb = new();
    agent_word_t        stim_q[$];
    bit                 written[TAB_DEPTH];
    bit                 tx_gaps   = 1'b1;
    bit                 rx_stalls = 1'b1;
    int                 stall_cycles = 0;

    radius_neighbor_average dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // word monitors and idle counter
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index_t'(cfg_index), cfg_data);
            if (s_tvalid && s_tready) sb.note_word(s_tdata, s_tuser);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        do @(posedge aclk); while (stall_cycles < WATCHDOG_LIMIT);
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAIL radius_neighbor_average");
        $finish;
    end

    // result side: random stalls, one long hold-off to back up the input
    initial begin
        int wait_n;
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        forever begin
            wait_n = rx_stalls ? $urandom_range(0, 15) : 0;
            if (!held && sb.checked >= HOLD_AFTER) begin
                wait_n = HOLD_CYCLES;
                held   = 1'b1;
            end
            if (wait_n > 0) begin
                m_tready <= 1'b0;
                repeat (wait_n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    function automatic void push_word(command_t cmd, int idx, int pres,
                                      int px, int py, int vx, int vy);
        agent_word_t w;
        w.cmd     = cmd;
        w.idx     = idx[INDEX_BITS-1:0];
        w.present = pres[0];
        w.px      = px[COORD_BITS-1:0];
        w.py      = py[COORD_BITS-1:0];
        w.vx      = vx[COORD_BITS-1:0];
        w.vy      = vy[COORD_BITS-1:0];
        if (cmd == CMD_WRITE) written[w.idx] = 1'b1;
        stim_q.insert(stim_q.size(), w);
    endfunction

    function automatic int pick_coord(int center, int spread);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80) return center + int'($urandom_range(0, 2 * spread)) - spread;
        if (sel < 95) return int'($urandom);
        case ($urandom_range(0, 3))
            0: return -32768;
            1: return 32767;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    // mostly table loads around one cluster, queries only of loaded entries
    task automatic build_phase(int n_words, int spread);
        int cx, cy, idx;
        cx = int'($urandom_range(0, 65535)) - 32768;
        cy = int'($urandom_range(0, 65535)) - 32768;
        repeat (n_words) begin
            if ($urandom_range(0, 99) < 45) begin
                do idx = $urandom_range(0, TAB_DEPTH - 1); while (!written[idx]);
                push_word(CMD_QUERY, idx, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                push_word(CMD_WRITE, $urandom_range(0, TAB_DEPTH - 1),
                          int'($urandom_range(0, 99) < 85),
                          pick_coord(cx, spread), pick_coord(cy, spread),
                          pick_coord(0, 32767), pick_coord(0, 32767));
            end
        end
    endtask

    task automatic send_queue();
        int gap;
        foreach (stim_q[k]) begin
            gap = tx_gaps ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= stim_q[k].cmd;
            s_tdata  <= {1'b0, stim_q[k].vy, stim_q[k].vx, stim_q[k].py, stim_q[k].px,
                         stim_q[k].present, stim_q[k].idx};
            do @(posedge aclk); while (!s_tready);
        end
        s_tvalid <= 1'b0;
        stim_q.delete();
    endtask

    // caller drops cfg_valid after its last write
    task automatic cfg_write(cfg_index_t idx, logic [RADIUS_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [RADIUS_BITS-1:0] rsq;
        logic [ACTIVE_BITS-1:0] act;
        int                     spread;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_RADIUS_SQUARED;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_WRITE;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: radius 15.0, 50 entries scanned
        push_word(CMD_WRITE, 0, 1, 0, 0, 32767, -32768);
        push_word(CMD_WRITE, 1, 1, 256, 0, -32768, 32767);
        push_word(CMD_WRITE, 2, 0, 0, 0, 100, 100);
        push_word(CMD_WRITE, 3, 1, 3840, 0, 5, 5);
        push_word(CMD_WRITE, 4, 1, 3839, 0, 1, -2);
        push_word(CMD_WRITE, 49, 1, 0, -3839, 7, 7);
        push_word(CMD_WRITE, 50, 1, 0, 0, -3, 3);
        push_word(CMD_WRITE, 63, 1, -32768, -32768, -1, -1);
        push_word(CMD_WRITE, 5, 1, 32767, 32767, 32767, 32767);
        push_word(CMD_WRITE, 6, 1, 32767, 32766, 32767, 32767);
        push_word(CMD_QUERY, 0, 1, -1, -1, -1, -1);
        push_word(CMD_QUERY, 2, 0, 0, 0, 0, 0);
        push_word(CMD_QUERY, 63, 0, 0, 0, 0, 0);
        push_word(CMD_QUERY, 50, 1, 32767, -32768, 0, 0);
        push_word(CMD_QUERY, 3, 0, 0, 0, 0, 0);
        push_word(CMD_QUERY, 5, 0, 0, 0, 0, 0);
        push_word(CMD_WRITE, 1, 0, 256, 0, -32768, 32767);
        push_word(CMD_QUERY, 0, 0, 0, 0, 0, 0);
        push_word(CMD_WRITE, 7, 1, -32768, 32767, -32768, -32768);
        push_word(CMD_WRITE, 8, 1, -32767, 32767, -32767, -32768);
        push_word(CMD_QUERY, 7, 1, 0, 0, 0, 0);
        send_queue();
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin rsq = 32'hFFFF_FFFF;  act = 7'd64;  spread = 20000; end
                1: begin rsq = 32'd0;          act = 7'd127; spread = 3000;  end
                2: begin rsq = 32'd1;          act = 7'd65;  spread = 1;     end
                3: begin rsq = 32'd1000000;    act = 7'd63;  spread = 800;   end
                4: begin rsq = RADIUS_SQ_RESET; act = 7'd0;  spread = 3000;  end
                5: begin rsq = 32'd50000000;   act = 7'd1;   spread = 6000;  end
                6: begin rsq = RADIUS_SQ_RESET; act = 7'd50; spread = 3000;  end
                default: begin
                    rsq    = $urandom;
                    act    = ACTIVE_BITS'($urandom_range(0, 127));
                    spread = $urandom_range(1, 20000);
                end
            endcase
            if (p[0]) begin
                cfg_write(CFG_ACTIVE_AGENTS, {{(RADIUS_BITS-ACTIVE_BITS){1'b0}}, act});
                cfg_write(CFG_RADIUS_SQUARED, rsq);
            end else begin
                cfg_write(CFG_RADIUS_SQUARED, rsq);
                cfg_write(CFG_ACTIVE_AGENTS, {{(RADIUS_BITS-ACTIVE_BITS){1'b0}}, act});
            end
            cfg_valid <= 1'b0;
            tx_gaps   = (p % 4) != 1;
            rx_stalls = (p % 4) != 2;
            build_phase(PHASE_WORDS, spread);
            send_queue();
            drain();
        end

        $display("Run covered %0d table writes and %0d queries over %0d register settings.",
                 sb.writes, sb.queries, NUM_PHASES + 1);
        $display("%0d result words checked, %0d with an empty neighborhood, %0d mismatches.",
                 sb.checked, sb.empties, sb.failures);
        if (sb.failures == 0) begin
            $display("PASS radius_neighbor_average");
        end else begin
            $display("FAIL radius_neighbor_average");
        end
        $finish;
    end

endmodule
